// ----- rtl/npi_pkg.sv -----
// ----------------------------------------------------------------------------
// npi_pkg
// Shared types and constants for the near-palindrome index block.
// ----------------------------------------------------------------------------
package npi_pkg;

  localparam int IDX_W   = 13;
  localparam int CODE_W  = 8;
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  // Index value that reports "no single removal" or "already a palindrome".
  localparam logic signed [IDX_W-1:0] NONE_IDX = '1;

  typedef struct packed {
    logic [CODE_W-1:0] char_code;
    logic              last_char;
  } npi_in_t;

  typedef struct packed {
    logic signed [IDX_W-1:0] removal_index;
    logic                    length_overflow;
  } npi_out_t;

  // Classified transaction passed from the front end to the search engine.
  typedef struct packed {
    logic [CODE_W-1:0] char_code;
    logic              last_char;
    logic              keep;      // byte fits in the buffer
    logic              overflow;  // string ran past the buffer (valid on last)
  } npi_item_t;

endpackage

// ----- rtl/npi_front.sv -----
// ----------------------------------------------------------------------------
// npi_front
// Input stage: accept bytes, track string length, mark kept or dropped bytes.
// ----------------------------------------------------------------------------
module npi_front import npi_pkg::*; #(
  parameter int MAX_LEN = 4096
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  npi_in_t   in_data,
  input  logic      q_full,
  output logic      q_push,
  output npi_item_t q_item
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LW = AW + 1;

  logic [LW-1:0] cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic          keep;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign keep     = (cnt_r < LW'(MAX_LEN));

  assign q_item.char_code = in_data.char_code;
  assign q_item.last_char = in_data.last_char;
  assign q_item.keep      = keep;
  assign q_item.overflow  = ovf_r || !keep;

  always_comb begin
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    if (q_push) begin
      if (in_data.last_char) begin
        // close the string: restart counting for the next one
        cnt_nxt = '0;
        ovf_nxt = 1'b0;
      end else if (keep) begin
        cnt_nxt = cnt_r + LW'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
    end
  end

endmodule

// ----- rtl/npi_queue.sv -----
// ----------------------------------------------------------------------------
// npi_queue
// Small FIFO that decouples the input stage from the search engine.
// ----------------------------------------------------------------------------
module npi_queue import npi_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  npi_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output npi_item_t head_item
);

  npi_item_t       slot_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]   cnt_r, cnt_nxt;

  assign full       = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_item  = slot_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + (Q_AW+1)'(1);
    if (!push && pop) cnt_nxt = cnt_r - (Q_AW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + Q_AW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + Q_AW'(1);
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/npi_back.sv -----
// ----------------------------------------------------------------------------
// npi_back
// Search engine: store bytes, then scan the buffer pairwise from both ends.
// ----------------------------------------------------------------------------
module npi_back import npi_pkg::*; #(
  parameter int MAX_LEN = 4096
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  npi_item_t q_item,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output npi_out_t  out_data
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LW = AW + 1;
  localparam int XW = (AW > IDX_W) ? AW : IDX_W;

  typedef enum logic [3:0] {
    S_LOAD = 4'b0001,
    S_RD   = 4'b0010,
    S_CMP  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  typedef enum logic [2:0] {
    M_SCAN    = 3'b001,
    M_SKIP_LO = 3'b010,
    M_SKIP_HI = 3'b100
  } mode_t;

  state_t state_r, state_nxt;
  mode_t  mode_r, mode_nxt;

  logic [CODE_W-1:0] mem [MAX_LEN];
  logic [CODE_W-1:0] rd_lo_r, rd_hi_r;
  logic              mem_we;

  logic [LW-1:0] wptr_r, wptr_nxt;
  logic [AW-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [AW-1:0] mlo_r, mlo_nxt, mhi_r, mhi_nxt;
  logic          ovf_r, ovf_nxt;
  logic signed [IDX_W-1:0] idx_r, idx_nxt;
  logic [XW-1:0] mlo_ext, mhi_ext;

  assign mlo_ext = XW'(mlo_r);
  assign mhi_ext = XW'(mhi_r);

  assign q_pop     = q_valid && (state_r == S_LOAD);
  assign mem_we    = q_pop && q_item.keep;
  assign out_valid = (state_r == S_OUT);
  assign out_data.removal_index   = idx_r;
  assign out_data.length_overflow = ovf_r;

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    wptr_nxt  = wptr_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mlo_nxt   = mlo_r;
    mhi_nxt   = mhi_r;
    ovf_nxt   = ovf_r;
    idx_nxt   = idx_r;
    case (state_r)
      S_LOAD: begin
        if (q_valid) begin
          if (q_item.keep) wptr_nxt = wptr_r + LW'(1);
          if (q_item.last_char) begin
            // last index is n-1: wptr itself when this byte was kept
            hi_nxt    = q_item.keep ? wptr_r[AW-1:0] : AW'(wptr_r - LW'(1));
            lo_nxt    = '0;
            wptr_nxt  = '0;
            ovf_nxt   = q_item.overflow;
            mode_nxt  = M_SCAN;
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        if (lo_r >= hi_r) begin
          state_nxt = S_OUT;
          case (mode_r)
            M_SKIP_LO: idx_nxt = $signed(mlo_ext[IDX_W-1:0]);
            M_SKIP_HI: idx_nxt = $signed(mhi_ext[IDX_W-1:0]);
            default:   idx_nxt = NONE_IDX;
          endcase
        end else begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        state_nxt = S_RD;
        if (rd_lo_r == rd_hi_r) begin
          lo_nxt = lo_r + AW'(1);
          hi_nxt = hi_r - AW'(1);
        end else begin
          case (mode_r)
            M_SCAN: begin
              // first mismatch: try skipping the low side
              mlo_nxt  = lo_r;
              mhi_nxt  = hi_r;
              lo_nxt   = lo_r + AW'(1);
              mode_nxt = M_SKIP_LO;
            end
            M_SKIP_LO: begin
              lo_nxt   = mlo_r;
              hi_nxt   = mhi_r - AW'(1);
              mode_nxt = M_SKIP_HI;
            end
            default: begin
              idx_nxt   = NONE_IDX;
              state_nxt = S_OUT;
            end
          endcase
        end
      end
      S_OUT: begin
        if (!out_stall) state_nxt = S_LOAD;
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wptr_r[AW-1:0]] <= q_item.char_code;
    rd_lo_r <= mem[lo_r];
    rd_hi_r <= mem[hi_r];
  end

  always_ff @(posedge clk) begin
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    mlo_r <= mlo_nxt;
    mhi_r <= mhi_nxt;
    ovf_r <= ovf_nxt;
    idx_r <= idx_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      mode_r  <= M_SCAN;
      wptr_r  <= '0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      wptr_r  <= wptr_nxt;
    end
  end

endmodule

// ----- rtl/near_palindrome_index.sv -----
// ----------------------------------------------------------------------------
// near_palindrome_index
// Single-deletion palindrome index over a byte string of up to MAX_LEN bytes.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle into the buffer while the engine is loading.
// Search: after the last byte leaves the queue, each pairwise compare is a
//   memory read (S_RD) followed by a compare (S_CMP), up to about N compares
//   for an N-byte string; the result is then registered into the output.
// The search engine's single pair of buffer read ports paces the search.
// Reset: synchronous, active low; clears the queue, counters and FSM.
//   The byte buffer is not cleared; only bytes of the current string are read.
// ----------------------------------------------------------------------------
module near_palindrome_index import npi_pkg::*; #(
  parameter int MAX_LEN = 4096
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  npi_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output npi_out_t out_data
);

  // Front end: classify each byte as kept or dropped and flag overflow.
  logic      q_full;
  logic      q_push;
  npi_item_t q_in_item;

  // Queue head toward the search engine.
  logic      q_valid;
  logic      q_pop;
  npi_item_t q_head;

  npi_front #(
    .MAX_LEN (MAX_LEN)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_in_item)
  );

  // Hold incoming transactions while the engine searches or waits on output.
  npi_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_in_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (q_head)
  );

  // Back end: store kept bytes; on the last byte, scan inward for the first
  // mismatch, then try skipping the low index, then the high index.
  npi_back #(
    .MAX_LEN (MAX_LEN)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
